// ----- hdl/pat_pkg.sv -----
// Shared types and constants for the peer address table.
// Used by the scan unit, the top level and the testbench.
package pat_pkg;

  localparam int ENTRIES      = 64;
  localparam int IDX_W        = $clog2(ENTRIES);
  localparam int CNT_W        = $clog2(ENTRIES + 1);
  localparam int FUTURE_SLACK = 600;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // Operation codes
  localparam logic [1:0] FUNC_ADD      = 2'd0;
  localparam logic [1:0] FUNC_GOOD     = 2'd1;
  localparam logic [1:0] FUNC_REMOVE   = 2'd2;
  localparam logic [1:0] FUNC_CONTAINS = 2'd3;

  // Result status codes
  localparam logic [3:0] ST_INSERTED = 4'd0;
  localparam logic [3:0] ST_EVICTED  = 4'd1;
  localparam logic [3:0] ST_RAISED   = 4'd2;
  localparam logic [3:0] ST_KEPT     = 4'd3;
  localparam logic [3:0] ST_SELF     = 4'd4;
  localparam logic [3:0] ST_PORT0    = 4'd5;
  localparam logic [3:0] ST_FUTURE   = 4'd6;
  localparam logic [3:0] ST_HIT      = 4'd7;
  localparam logic [3:0] ST_MISS     = 4'd8;

  // Configuration register indexes
  localparam logic CFG_SELF_IPV4 = 1'b0;
  localparam logic CFG_SELF_PORT = 1'b1;

  typedef struct packed {
    logic [31:0] ipv4;
    logic [15:0] port;
    logic [31:0] last_seen;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  // Running results of one scan over all slots
  typedef struct packed {
    logic        hit;
    idx_t        hit_idx;
    logic [31:0] hit_time;
    logic        free_found;
    idx_t        free_idx;
    logic        old_found;
    idx_t        old_idx;
    logic [31:0] old_time;
    logic [31:0] old_ipv4;
    logic [15:0] old_port;
  } scan_res_t;

endpackage

// ----- hdl/pat_if.sv -----
// Valid/ready channel interfaces: request, response and configuration write.
// Payload widths are fixed by the item formats; no package dependency.
interface pat_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [31:0] address_ipv4;
  logic [15:0] port_number;
  logic [31:0] stamp;
  logic [31:0] now_secs;

  modport source (output valid, func, address_ipv4, port_number, stamp, now_secs,
                  input ready);
  modport sink   (input valid, func, address_ipv4, port_number, stamp, now_secs,
                  output ready);
endinterface

interface pat_rsp_if;
  logic        valid;
  logic        ready;
  logic [3:0]  status;
  logic        found;
  logic [6:0]  entry_count;
  logic [31:0] evicted_ipv4;
  logic [15:0] evicted_port;

  modport source (output valid, status, found, entry_count, evicted_ipv4, evicted_port,
                  input ready);
  modport sink   (input valid, status, found, entry_count, evicted_ipv4, evicted_port,
                  output ready);
endinterface

interface pat_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- hdl/pat_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/pat_scan.sv -----
// Shared per-slot compare unit: key match, oldest stamp and first free slot.
// Depends on pat_pkg; fed one slot per cycle by the top-level sequencer.
module pat_scan import pat_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        clear_i,
  input  logic        chk_vld_i,
  input  idx_t        chk_idx_i,
  input  logic        slot_vld_i,
  input  slot_t       slot_i,
  input  logic [31:0] key_ipv4_i,
  input  logic [15:0] key_port_i,
  output scan_res_t   res_o
);

  scan_res_t res_q, res_d;
  logic      live, match, older, free;

  assign live  = chk_vld_i && slot_vld_i;
  assign match = live && (slot_i.ipv4 == key_ipv4_i) && (slot_i.port == key_port_i);
  // Strict less-than keeps the lowest slot on a tie
  assign older = live && (!res_q.old_found || (slot_i.last_seen < res_q.old_time));
  assign free  = chk_vld_i && !slot_vld_i;

  always_comb begin
    res_d = res_q;
    if (clear_i) begin
      res_d.hit        = 1'b0;
      res_d.free_found = 1'b0;
      res_d.old_found  = 1'b0;
    end else begin
      if (match && !res_q.hit) begin
        res_d.hit      = 1'b1;
        res_d.hit_idx  = chk_idx_i;
        res_d.hit_time = slot_i.last_seen;
      end
      if (free && !res_q.free_found) begin
        res_d.free_found = 1'b1;
        res_d.free_idx   = chk_idx_i;
      end
      if (older) begin
        res_d.old_found = 1'b1;
        res_d.old_idx   = chk_idx_i;
        res_d.old_time  = slot_i.last_seen;
        res_d.old_ipv4  = slot_i.ipv4;
        res_d.old_port  = slot_i.port;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= '0;
    end else begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

// ----- hdl/peer_address_table_core.sv -----
// Peer address table top level: sequencer, slot storage, valid bits, output register.
// Depends on pat_pkg, pat_if (channel interfaces), pat_ram and pat_scan.
//
//   channel  dir  handshake      payload
//   req_i    in   valid/ready    func, address_ipv4, port_number, stamp, now_secs
//   rsp_o    out  valid/ready    status, found, entry_count, evicted_ipv4, evicted_port
//   cfg_i    in   valid/ready    index (0 self_ipv4, 1 self_port), data
//
// A request runs through the scan, drain and decide/write states before the next
// one is accepted: the slot RAM has one read port and every slot is read once per
// operation.
// Reset clears the valid bits, the entry count and the own key at once; no clearing
// pass is needed. The finished result sits in an output register, so a new request
// is taken while it waits; the decide step holds only if that register is still full.
// Configuration writes are always accepted.
module peer_address_table_core import pat_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  pat_req_if.sink   req_i,
  pat_rsp_if.source rsp_o,
  pat_cfg_if.sink   cfg_i
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_DRAIN  = 2'd2;
  localparam logic [1:0] S_DECIDE = 2'd3;

  logic [1:0] state_q, state_d;
  idx_t       cnt_q, cnt_d;
  logic       chk_vld_q;
  idx_t       chk_idx_q;

  // Latched request
  logic [1:0]  func_q;
  logic [31:0] ipv4_q;
  logic [15:0] port_q;
  logic [31:0] stamp_q;
  logic [31:0] now_q;

  // Own key
  logic [31:0] self_ipv4_q;
  logic [15:0] self_port_q;

  logic [ENTRIES-1:0] valid_q, valid_d;
  cnt_t               count_q, count_d;

  // Output register
  logic        out_vld_q;
  logic [3:0]  out_status_q, status_d;
  logic        out_found_q;
  logic [6:0]  out_count_q;
  logic [31:0] out_ev_ipv4_q, ev_ipv4_d;
  logic [15:0] out_ev_port_q, ev_port_d;

  logic      req_acc, decide_go;
  logic      ram_we;
  idx_t      ram_waddr;
  slot_t     ram_wdata, ram_rdata;
  scan_res_t scan;
  logic      self_match, future;

  assign req_acc      = req_i.valid && req_i.ready;
  assign req_i.ready  = (state_q == S_IDLE);
  assign cfg_i.ready  = 1'b1;
  assign decide_go    = (state_q == S_DECIDE) && (!out_vld_q || rsp_o.ready);

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      self_ipv4_q <= '0;
      self_port_q <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_SELF_IPV4: self_ipv4_q <= cfg_i.data;
        CFG_SELF_PORT: self_port_q <= cfg_i.data[15:0];
        default:       self_ipv4_q <= self_ipv4_q;
      endcase
    end
  end

  // Latch the request on acceptance
  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      func_q  <= req_i.func;
      ipv4_q  <= req_i.address_ipv4;
      port_q  <= req_i.port_number;
      stamp_q <= req_i.stamp;
      now_q   <= req_i.now_secs;
    end
  end

  // Sequencer: issue one slot read per cycle, drain the RAM latency, then decide
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      S_IDLE: begin
        if (req_acc) begin
          state_d = S_SCAN;
          cnt_d   = '0;
        end
      end
      S_SCAN: begin
        cnt_d = cnt_q + idx_t'(1);
        if (cnt_q == idx_t'(ENTRIES - 1)) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: state_d = S_DECIDE;
      S_DECIDE: begin
        if (decide_go) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      chk_vld_q <= 1'b0;
      chk_idx_q <= '0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      // Read data for slot chk_idx_q arrives in the cycle after its address
      chk_vld_q <= (state_q == S_SCAN);
      chk_idx_q <= cnt_q;
    end
  end

  pat_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (ENTRIES)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (state_q == S_SCAN),
    .raddr_i (cnt_q),
    .rdata_o (ram_rdata)
  );

  pat_scan u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clear_i    (req_acc),
    .chk_vld_i  (chk_vld_q),
    .chk_idx_i  (chk_idx_q),
    .slot_vld_i (valid_q[chk_idx_q]),
    .slot_i     (ram_rdata),
    .key_ipv4_i (ipv4_q),
    .key_port_i (port_q),
    .res_o      (scan)
  );

  assign self_match = (ipv4_q == self_ipv4_q) && (port_q == self_port_q);
  // 33-bit compare so now + slack cannot wrap
  assign future     = {1'b0, stamp_q} > ({1'b0, now_q} + 33'(FUTURE_SLACK));

  // Decide: pick the status, the slot write and the valid/count update
  always_comb begin
    valid_d   = valid_q;
    count_d   = count_q;
    ram_we    = 1'b0;
    ram_waddr = scan.hit_idx;
    ram_wdata = '{ipv4: ipv4_q, port: port_q, last_seen: stamp_q};
    status_d  = ST_MISS;
    ev_ipv4_d = '0;
    ev_port_d = '0;
    if (func_q == FUNC_ADD) begin
      if (self_match) begin
        status_d = ST_SELF;
      end else if (port_q == '0) begin
        status_d = ST_PORT0;
      end else if (future) begin
        status_d = ST_FUTURE;
      end else if (scan.hit) begin
        if (stamp_q > scan.hit_time) begin
          status_d = ST_RAISED;
          ram_we   = decide_go;
        end else begin
          status_d = ST_KEPT;
        end
      end else if (count_q == cnt_t'(ENTRIES)) begin
        // Full: replace the oldest entry in place, count unchanged
        status_d  = ST_EVICTED;
        ram_we    = decide_go;
        ram_waddr = scan.old_idx;
        ev_ipv4_d = scan.old_ipv4;
        ev_port_d = scan.old_port;
      end else begin
        status_d  = ST_INSERTED;
        ram_we    = decide_go;
        ram_waddr = scan.free_idx;
        if (decide_go) begin
          valid_d[scan.free_idx] = 1'b1;
        end
        count_d   = count_q + cnt_t'(1);
      end
    end else if (scan.hit) begin
      status_d = ST_HIT;
      case (func_q)
        FUNC_GOOD: begin
          ram_we              = decide_go;
          ram_wdata.last_seen = now_q;
        end
        FUNC_REMOVE: begin
          if (decide_go) begin
            valid_d[scan.hit_idx] = 1'b0;
          end
          count_d = count_q - cnt_t'(1);
        end
        default: status_d = ST_HIT;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      count_q <= '0;
    end else if (decide_go) begin
      valid_q <= valid_d;
      count_q <= count_d;
    end
  end

  // Output register: load on decide, drop when the response transaction completes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (decide_go) begin
      out_vld_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (decide_go) begin
      out_status_q  <= status_d;
      out_found_q   <= scan.hit;
      out_count_q   <= 7'(count_d);
      out_ev_ipv4_q <= ev_ipv4_d;
      out_ev_port_q <= ev_port_d;
    end
  end

  assign rsp_o.valid        = out_vld_q;
  assign rsp_o.status       = out_status_q;
  assign rsp_o.found        = out_found_q;
  assign rsp_o.entry_count  = out_count_q;
  assign rsp_o.evicted_ipv4 = out_ev_ipv4_q;
  assign rsp_o.evicted_port = out_ev_port_q;

endmodule

// ----- tb/pat_table_checker.sv -----
// Scoreboard for the peer address table: watches the request, response and
// configuration channels, keeps a shadow table and checks every response.
// Depends on pat_pkg and the channel interfaces in pat_if.
module pat_table_checker import pat_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  pat_req_if          req_i,
  pat_rsp_if          rsp_i,
  pat_cfg_if          cfg_i,
  output int unsigned err_cnt_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PRINT_CAP = 100;

  typedef struct packed {
    logic [3:0]  status;
    logic        found;
    logic [6:0]  count;
    logic [31:0] ev_ip;
    logic [15:0] ev_port;
  } peer_result_t;

  logic        tbl_valid [ENTRIES];
  logic [31:0] tbl_ip    [ENTRIES];
  logic [15:0] tbl_port  [ENTRIES];
  logic [31:0] tbl_seen  [ENTRIES];
  int unsigned n_valid;
  logic [31:0] own_ip;
  logic [15:0] own_port;

  peer_result_t want_rsp_q [$];

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    if (err_cnt_o < PRINT_CAP)
      $display("%0t mismatch %s: got %h, want %h", $time, what, got, want);
    err_cnt_o++;
  endtask

  // Apply one operation to the shadow table and return the response it owes.
  function automatic peer_result_t apply_op(input logic [1:0] fn, input logic [31:0] ip,
                                            input logic [15:0] port,
                                            input logic [31:0] stamp,
                                            input logic [31:0] now);
    peer_result_t res;
    int hit;
    int victim;
    int free_slot;
    res = '0;
    hit = -1;
    victim = -1;
    free_slot = -1;
    for (int i = 0; i < ENTRIES; i++)
      if (hit < 0 && tbl_valid[i] && tbl_ip[i] == ip && tbl_port[i] == port) hit = i;
    res.found = (hit >= 0);
    if (fn == FUNC_ADD) begin
      if (ip == own_ip && port == own_port) begin
        res.status = ST_SELF;
      end else if (port == 16'd0) begin
        res.status = ST_PORT0;
      end else if ({1'b0, stamp} > {1'b0, now} + 33'(FUTURE_SLACK)) begin
        res.status = ST_FUTURE;
      end else if (hit >= 0) begin
        if (stamp > tbl_seen[hit]) begin
          tbl_seen[hit] = stamp;
          res.status = ST_RAISED;
        end else begin
          res.status = ST_KEPT;
        end
      end else begin
        res.status = ST_INSERTED;
        if (n_valid >= ENTRIES) begin
          // oldest stamp goes; ties resolve to the lowest slot
          for (int i = 0; i < ENTRIES; i++)
            if (tbl_valid[i] && (victim < 0 || tbl_seen[i] < tbl_seen[victim])) victim = i;
          if (victim >= 0) begin
            res.ev_ip   = tbl_ip[victim];
            res.ev_port = tbl_port[victim];
            tbl_valid[victim] = 1'b0;
            n_valid--;
            res.status = ST_EVICTED;
          end
        end
        for (int i = 0; i < ENTRIES; i++)
          if (free_slot < 0 && !tbl_valid[i]) free_slot = i;
        if (free_slot >= 0) begin
          tbl_valid[free_slot] = 1'b1;
          tbl_ip[free_slot]    = ip;
          tbl_port[free_slot]  = port;
          tbl_seen[free_slot]  = stamp;
          n_valid++;
        end
      end
    end else begin
      res.status = (hit >= 0) ? ST_HIT : ST_MISS;
      if (hit >= 0 && fn == FUNC_GOOD) tbl_seen[hit] = now;
      if (hit >= 0 && fn == FUNC_REMOVE) begin
        tbl_valid[hit] = 1'b0;
        n_valid--;
      end
    end
    res.count = 7'(n_valid);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    peer_result_t want;
    if (!rst_ni) begin
      for (int i = 0; i < ENTRIES; i++) tbl_valid[i] = 1'b0;
      n_valid   = 0;
      own_ip    = '0;
      own_port  = '0;
      want_rsp_q.delete();
      pending_o = 0;
    end else begin
      if (rsp_i.valid && rsp_i.ready) begin
        if (want_rsp_q.size() == 0) begin
          flag_mismatch("response with nothing outstanding", 32'(rsp_i.status), '0);
        end else begin
          want = want_rsp_q.pop_front();
          if (rsp_i.status !== want.status)
            flag_mismatch("status", 32'(rsp_i.status), 32'(want.status));
          if (rsp_i.found !== want.found)
            flag_mismatch("found", 32'(rsp_i.found), 32'(want.found));
          if (rsp_i.entry_count !== want.count)
            flag_mismatch("entry_count", 32'(rsp_i.entry_count), 32'(want.count));
          if (rsp_i.evicted_ipv4 !== want.ev_ip)
            flag_mismatch("evicted_ipv4", rsp_i.evicted_ipv4, want.ev_ip);
          if (rsp_i.evicted_port !== want.ev_port)
            flag_mismatch("evicted_port", 32'(rsp_i.evicted_port), 32'(want.ev_port));
        end
      end
      if (cfg_i.valid && cfg_i.ready) begin
        if (cfg_i.index == CFG_SELF_IPV4) own_ip = cfg_i.data;
        else own_port = cfg_i.data[15:0];
      end
      if (req_i.valid && req_i.ready) begin
        want = apply_op(req_i.func, req_i.address_ipv4, req_i.port_number,
                        req_i.stamp, req_i.now_secs);
        want_rsp_q.insert(want_rsp_q.size(), want);
      end
      pending_o = want_rsp_q.size();
    end
  end

endmodule

// ----- tb/tb.sv -----
// Top of the peer address table testbench: clock, reset, request and config stimulus,
// response back-pressure and the final verdict.
// Depends on pat_pkg, pat_if, peer_address_table_core and pat_table_checker.
module tb import pat_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          POOL           = 100;   // keys the random traffic draws from
  localparam int          PHASES         = 5;
  localparam int          OPS_PER_PHASE  = 350;
  localparam int unsigned SQUEEZE_CYCLES = 1500;  // long response hold-off
  localparam int unsigned SETTLE_CYCLES  = 80;    // a bit longer than one full operation

  logic clk = 1'b0;
  logic rst_n;

  pat_req_if req_if ();
  pat_rsp_if rsp_if ();
  pat_cfg_if cfg_if ();

  int unsigned err_cnt;
  int unsigned pending;

  // Traffic knobs, changed between phases
  bit          quiet;         // no idling on either side
  bit          squeeze_go;    // ask the response side for its long hold-off
  bit          squeeze_done;
  bit          tie_mode;      // stamps from a handful of values so evictions tie
  logic [31:0] tie_base;
  logic [31:0] clock_s;       // running "now" for well-formed traffic
  logic [31:0] own_ip;
  logic [15:0] own_port;
  logic [31:0] pool_ip   [POOL];
  logic [15:0] pool_port [POOL];

  peer_address_table_core u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  pat_table_checker u_checker (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .req_i     (req_if),
    .rsp_i     (rsp_if),
    .cfg_i     (cfg_if),
    .err_cnt_o (err_cnt),
    .pending_o (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Gap length for either side: mostly none or short, now and then long.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 50) return 0;
    if (r < 88) return $urandom_range(1, 4);
    if (r < 97) return $urandom_range(5, 30);
    return $urandom_range(60, 200);
  endfunction

  // Offer one request and hold it until the core takes it. Valid stays high on
  // return so a back-to-back request keeps it up without a glitch.
  task automatic push_op(input logic [1:0] fn, input logic [31:0] ip, input logic [15:0] port,
                         input logic [31:0] stamp, input logic [31:0] now);
    int unsigned gap;
    gap = idle_len();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid        <= 1'b1;
    req_if.func         <= fn;
    req_if.address_ipv4 <= ip;
    req_if.port_number  <= port;
    req_if.stamp        <= stamp;
    req_if.now_secs     <= now;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
  endtask

  // Drop valid and wait until every response the checker is owed has come back.
  task automatic drain();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Write both own-key registers back to back; call only while the core is idle.
  task automatic set_own_key(input logic [31:0] ip, input logic [15:0] port);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= CFG_SELF_IPV4;
    cfg_if.data  <= ip;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.index <= CFG_SELF_PORT;
    cfg_if.data  <= {16'd0, port};
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    own_ip   = ip;
    own_port = port;
  endtask

  // One random request. Most keys come from the pool so hits, refreshes and a full
  // table with evictions happen; a few are the own key or fully random noise.
  task automatic random_op();
    logic [1:0]  fn;
    logic [31:0] ip;
    logic [15:0] port;
    logic [31:0] stamp;
    logic [31:0] now;
    int unsigned pick;
    int unsigned k;
    pick = $urandom_range(0, 99);
    if (pick < 55)      fn = FUNC_ADD;
    else if (pick < 67) fn = FUNC_GOOD;
    else if (pick < 77) fn = FUNC_REMOVE;
    else                fn = FUNC_CONTAINS;
    pick = $urandom_range(0, 99);
    if (pick < 92) begin
      k    = $urandom_range(0, POOL - 1);
      ip   = pool_ip[k];
      port = pool_port[k];
    end else if (pick < 96) begin
      ip   = own_ip;
      port = own_port;
    end else begin
      ip   = $urandom;
      port = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom);
    end
    clock_s += $urandom_range(0, 40);
    now = ($urandom_range(0, 99) < 3) ? $urandom : clock_s;
    pick = $urandom_range(0, 99);
    if (tie_mode && pick < 70) stamp = tie_base + 32'(10 * $urandom_range(0, 3));
    else if (pick < 78)        stamp = now - $urandom_range(0, 3000);
    else if (pick < 88)        stamp = now + $urandom_range(0, 600);
    else if (pick < 92)        stamp = now + 32'(FUTURE_SLACK) + 32'd1 + $urandom_range(0, 5);
    else if (pick < 95)        stamp = now + 32'(FUTURE_SLACK);
    else                       stamp = $urandom;
    push_op(fn, ip, port, stamp, now);
  endtask

  // Response side: random ready with short and long stalls, plus one long hold-off
  // during which the core fills its output register and stalls its request side.
  initial begin : rsp_side
    int unsigned run;
    int unsigned gap;
    rsp_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (squeeze_go && !squeeze_done) begin
        rsp_if.ready <= 1'b0;
        repeat (SQUEEZE_CYCLES) @(posedge clk);
        squeeze_done = 1'b1;
      end
      rsp_if.ready <= 1'b1;
      run = $urandom_range(1, 40);
      repeat (run) @(posedge clk);
      gap = idle_len();
      if (gap > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    quiet        = 1'b0;
    squeeze_go   = 1'b0;
    squeeze_done = 1'b0;
    tie_mode     = 1'b0;
    tie_base     = '0;
    own_ip       = '0;
    own_port     = '0;
    rst_n               <= 1'b0;
    req_if.valid        <= 1'b0;
    req_if.func         <= FUNC_ADD;
    req_if.address_ipv4 <= '0;
    req_if.port_number  <= '0;
    req_if.stamp        <= '0;
    req_if.now_secs     <= '0;
    cfg_if.valid        <= 1'b0;
    cfg_if.index        <= CFG_SELF_IPV4;
    cfg_if.data         <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < POOL; i++) begin
      pool_ip[i]   = $urandom;
      pool_port[i] = 16'($urandom_range(1, 65535));
    end
    clock_s = 32'd1_000_000 + $urandom_range(0, 100_000);

    // Directed part, own key still at its reset value 0.0.0.0:0.
    push_op(FUNC_CONTAINS, 32'h0A00_0001, 16'd80, 32'd0, 32'd100);   // empty table miss
    push_op(FUNC_ADD, 32'd0, 16'd0, 32'd0, 32'd0);                   // own key beats port zero
    push_op(FUNC_ADD, 32'd0, 16'd0, 32'hFFFF_FFFF, 32'd0);           // own key beats future
    push_op(FUNC_ADD, 32'h0A00_0001, 16'd0, 32'hFFFF_FFFF, 32'd0);   // port zero beats future
    push_op(FUNC_ADD, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF); // no wrap
    push_op(FUNC_ADD, 32'h0A00_0001, 16'd80, 32'd601, 32'd0);        // just in the future
    push_op(FUNC_ADD, 32'h0A00_0001, 16'd80, 32'd600, 32'd0);        // right at the limit
    push_op(FUNC_ADD, 32'h0A00_0001, 16'd80, 32'd5, 32'd0);          // older stamp kept out
    push_op(FUNC_ADD, 32'h0A00_0001, 16'd80, 32'd900, 32'd300);      // newer stamp raises
    push_op(FUNC_ADD, 32'h0A00_0001, 16'd80, 32'h0000_0FFF, 32'd0);  // future on a known key
    push_op(FUNC_GOOD, 32'h0A00_0001, 16'd80, 32'd0, 32'h0000_1234);
    push_op(FUNC_ADD, 32'h0A00_0001, 16'd80, 32'h0000_1000, 32'h0000_1234); // below marked
    push_op(FUNC_CONTAINS, 32'hFFFF_FFFF, 16'hFFFF, 32'd0, 32'd0);
    push_op(FUNC_REMOVE, 32'hFFFF_FFFF, 16'hFFFF, 32'd0, 32'd0);
    push_op(FUNC_REMOVE, 32'hFFFF_FFFF, 16'hFFFF, 32'd0, 32'd0);     // already gone
    push_op(FUNC_GOOD, 32'hFFFF_FFFF, 16'hFFFF, 32'd0, 32'd7);       // mark good on a miss
    push_op(FUNC_CONTAINS, 32'd0, 16'd0, 32'd0, 32'd0);              // own key is a plain lookup
    push_op(FUNC_GOOD, 32'h0A00_0001, 16'd0, 32'd0, 32'd0);          // port zero lookup
    push_op(FUNC_ADD, 32'd0, 16'd1, 32'd0, 32'd0);                   // zero address, legal port
    drain();

    // Own key moved onto a stored entry: the entry stays, only adds are refused.
    set_own_key(32'h0A00_0001, 16'd80);
    push_op(FUNC_CONTAINS, 32'h0A00_0001, 16'd80, 32'd0, 32'd0);
    push_op(FUNC_ADD, 32'h0A00_0001, 16'd80, 32'd0, 32'd0);
    push_op(FUNC_REMOVE, 32'h0A00_0001, 16'd80, 32'd0, 32'd0);

    // Random phases, each with its own own-key setting and traffic flavor.
    for (int p = 0; p < PHASES; p++) begin
      drain();
      case (p)
        0: set_own_key(pool_ip[7], pool_port[7]);
        1: set_own_key(32'hFFFF_FFFF, 16'hFFFF);
        2: set_own_key(32'd0, 16'd0);
        3: set_own_key($urandom, 16'($urandom));
        default: set_own_key(pool_ip[0], pool_port[0]);
      endcase
      quiet      = (p == 2);
      tie_mode   = (p == 2);
      tie_base   = clock_s;
      squeeze_go = (p == 1);
      if (p == 3) clock_s = 32'hFFFF_E000;   // let time run across the top of the range
      repeat (OPS_PER_PHASE) random_op();
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run.
  initial begin : watchdog
    #40ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
